// File: hdl/min_priority_queue_with_update_core_assert.svh
// Assertion macros shared by the queue RTL.
`ifndef MIN_PRIORITY_QUEUE_WITH_UPDATE_CORE_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_WITH_UPDATE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define MPQ_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPQ_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define MPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hdl/mpq_pkg.sv
package mpq_pkg;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UPDATED = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } mpq_status_t;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic wr_en;   // an item is accepted this cycle
        logic ins_en;  // the key entry is placed in the row
    } mpq_ctrl_t;

endpackage

// File: hdl/mpq_prefix_or.sv
module mpq_prefix_or #(
    parameter int N = 64
) (
    input  logic [N-1:0] din,
    output logic [N-1:0] dout
);
    localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

    // Log-depth inclusive prefix OR: dout[k] = |din[k:0]
    logic [N-1:0] lvl [0:LEVELS];

    assign lvl[0] = din;

    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
        assign lvl[l+1] = lvl[l] | (lvl[l] << (1 << l));
    end

    assign dout = lvl[LEVELS];

endmodule

// File: hdl/mpq_cell.sv
module mpq_cell #(
    parameter int ID_BITS     = 16,
    parameter int WEIGHT_BITS = 31,
    parameter int CNT_W       = 7,
    parameter int INDEX       = 0
) (
    input  logic                   clk,
    input  mpq_pkg::mpq_ctrl_t     ctrl,
    input  logic [ID_BITS-1:0]     key_id,
    input  logic [WEIGHT_BITS-1:0] key_weight,
    input  logic [CNT_W-1:0]       cnt,
    input  logic [ID_BITS-1:0]     prev_id,
    input  logic [WEIGHT_BITS-1:0] prev_weight,
    input  logic                   prev_gt,
    input  logic                   rm_prev,
    input  logic [ID_BITS-1:0]     next_id,
    input  logic [WEIGHT_BITS-1:0] next_weight,
    input  logic                   next_gt,
    input  logic                   rm_here,
    output logic [ID_BITS-1:0]     id,
    output logic [WEIGHT_BITS-1:0] weight,
    output logic                   gt,
    output logic                   match
);
    import mpq_pkg::*;

    logic [ID_BITS-1:0]     id_reg, id_next;
    logic [WEIGHT_BITS-1:0] weight_reg, weight_next;
    logic                   valid;
    logic                   gts_here, gts_prev;
    logic [ID_BITS-1:0]     s_here_id, s_prev_id;
    logic [WEIGHT_BITS-1:0] s_here_w, s_prev_w;

    // Empty slots count as heavier than anything, so gt stays monotone along the row.
    assign valid  = CNT_W'(INDEX) < cnt;
    assign gt     = !valid || (weight_reg > key_weight);
    assign match  = valid && (id_reg == key_id);
    assign id     = id_reg;
    assign weight = weight_reg;

    always_comb
    begin
        // Row after the removal: entries at or past the removed one move down.
        s_here_id = rm_here ? next_id     : id_reg;
        s_here_w  = rm_here ? next_weight : weight_reg;
        gts_here  = rm_here ? next_gt     : gt;
        s_prev_id = rm_prev ? id_reg      : prev_id;
        s_prev_w  = rm_prev ? weight_reg  : prev_weight;
        gts_prev  = rm_prev ? gt          : prev_gt;

        id_next     = s_here_id;
        weight_next = s_here_w;
        if (ctrl.ins_en) begin
            if (gts_prev) begin
                id_next     = s_prev_id;
                weight_next = s_prev_w;
            end else if (gts_here) begin
                id_next     = key_id;
                weight_next = key_weight;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en) begin
            id_reg     <= id_next;
            weight_reg <= weight_next;
        end
    end

endmodule

// File: hdl/min_priority_queue_with_update_core.sv
// Sorted minimum priority queue with update, built as a row of CAPACITY
// compare-and-shift cells. Every operation (insert, weight update of a held
// id, pop of the lightest entry) updates the whole row at once: an item is
// taken each cycle while the output register is empty or being drained, and
// its result appears on m_* the cycle after acceptance. Equal weights are
// served oldest first; an updated entry counts as newly placed. The cycle is
// set by the id match flags going through a log2(CAPACITY)-level prefix OR
// and the per-cell weight compare feeding the cell shift muxes. No clearing
// pass is needed after reset: only the fill count and output valid are cleared.
`include "min_priority_queue_with_update_core_assert.svh"

module min_priority_queue_with_update_core #(
    parameter int CAPACITY    = 64,
    parameter int ID_BITS     = 16,
    parameter int WEIGHT_BITS = 31,
    localparam int CNT_W       = $clog2(CAPACITY + 1),
    localparam int IN_W        = ID_BITS + WEIGHT_BITS,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W       = ID_BITS + WEIGHT_BITS + CNT_W,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // node_id, node_weight
    input  logic [0:0]             s_tuser,   // func
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // popped_id, popped_weight, occupancy
    output logic [1:0]             m_tuser    // status
);
    import mpq_pkg::*;

    logic                   accept;
    logic                   func;
    logic [ID_BITS-1:0]     key_id;
    logic [WEIGHT_BITS-1:0] key_weight;

    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   m_valid_reg;
    logic [ID_BITS-1:0]     m_id_reg, m_id_next;
    logic [WEIGHT_BITS-1:0] m_weight_reg, m_weight_next;
    mpq_status_t            m_status_reg, m_status_next;
    logic [CNT_W-1:0]       m_occ_reg;

    logic [ID_BITS-1:0]     cell_id     [0:CAPACITY-1];
    logic [WEIGHT_BITS-1:0] cell_weight [0:CAPACITY-1];
    logic [CAPACITY-1:0]    cell_gt;
    logic [CAPACITY-1:0]    match_vec;
    logic [CAPACITY-1:0]    match_pfx;
    logic [CAPACITY-1:0]    rm_vec;
    logic                   found, full, empty;
    mpq_ctrl_t              ctrl;

    assign func       = s_tuser[0];
    assign key_id     = s_tdata[ID_BITS-1:0];
    assign key_weight = s_tdata[IN_W-1:ID_BITS];
    assign s_tready   = !m_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;

    assign found = |match_vec;
    assign full  = cnt_reg == CNT_W'(CAPACITY);
    assign empty = cnt_reg == '0;

    mpq_prefix_or #(
        .N (CAPACITY)
    ) u_pfx (
        .din  (match_vec),
        .dout (match_pfx)
    );

    // A pop removes the head; an update removes the matched entry.
    assign rm_vec = (func == FUNC_POP) ? {CAPACITY{1'b1}} : match_pfx;

    assign ctrl.wr_en  = accept;
    assign ctrl.ins_en = (func == FUNC_PUSH) && (found || !full);

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [ID_BITS-1:0]     p_id, n_id;
        logic [WEIGHT_BITS-1:0] p_w, n_w;
        logic                   p_gt, n_gt, p_rm;

        if (k == 0) begin : g_first
            assign p_id = '0;
            assign p_w  = '0;
            assign p_gt = 1'b0;
            assign p_rm = 1'b0;
        end else begin : g_mid
            assign p_id = cell_id[k-1];
            assign p_w  = cell_weight[k-1];
            assign p_gt = cell_gt[k-1];
            assign p_rm = rm_vec[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign n_id = '0;
            assign n_w  = '0;
            assign n_gt = 1'b1;
        end else begin : g_inner
            assign n_id = cell_id[k+1];
            assign n_w  = cell_weight[k+1];
            assign n_gt = cell_gt[k+1];
        end

        mpq_cell #(
            .ID_BITS     (ID_BITS),
            .WEIGHT_BITS (WEIGHT_BITS),
            .CNT_W       (CNT_W),
            .INDEX       (k)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .key_id      (key_id),
            .key_weight  (key_weight),
            .cnt         (cnt_reg),
            .prev_id     (p_id),
            .prev_weight (p_w),
            .prev_gt     (p_gt),
            .rm_prev     (p_rm),
            .next_id     (n_id),
            .next_weight (n_w),
            .next_gt     (n_gt),
            .rm_here     (rm_vec[k]),
            .id          (cell_id[k]),
            .weight      (cell_weight[k]),
            .gt          (cell_gt[k]),
            .match       (match_vec[k])
        );
    end

    always_comb
    begin
        cnt_next      = cnt_reg;
        m_id_next     = '0;
        m_weight_next = '0;
        m_status_next = ST_OK;
        if (func == FUNC_POP) begin
            if (empty) begin
                m_status_next = ST_EMPTY;
            end else begin
                m_id_next     = cell_id[0];
                m_weight_next = cell_weight[0];
                cnt_next      = cnt_reg - CNT_W'(1);
            end
        end else begin
            priority if (found) begin
                m_status_next = ST_UPDATED;
            end else if (full) begin
                m_status_next = ST_FULL;
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cnt_reg <= cnt_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            m_id_reg     <= m_id_next;
            m_weight_reg <= m_weight_next;
            m_status_reg <= m_status_next;
            m_occ_reg    <= cnt_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({m_occ_reg, m_weight_reg, m_id_reg});
    assign m_tuser  = m_status_reg;

    `MPQ_ASSERT_RST(a_cnt_range, clk, rst_n, cnt_reg <= CNT_W'(CAPACITY), "fill count beyond capacity")
    `MPQ_ASSERT_RST(a_id_unique, clk, rst_n, $onehot0(match_vec), "id held in more than one cell")
    `MPQ_ASSERT_RST(a_pop_dec, clk, rst_n, accept && func == FUNC_POP && !empty |=> cnt_reg == $past(cnt_reg) - CNT_W'(1), "pop did not shrink queue")
    `MPQ_ASSERT_RST(a_result_follows, clk, rst_n, accept |=> m_tvalid, "accepted item produced no result")
    `MPQ_ASSERT_RST(a_full_occ, clk, rst_n, m_tvalid && m_tuser == ST_FULL |-> m_occ_reg == CNT_W'(CAPACITY), "full status with queue not full")

endmodule
